### src/box_table_hit_select_assert.svh
// assertion macros for the box table hit select block
// used by the checker; expects clk and arst_n in the scope of use
`ifndef BOX_TABLE_HIT_SELECT_ASSERT_SVH
`define BOX_TABLE_HIT_SELECT_ASSERT_SVH

// same-cycle implication
`define BTHS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BTHS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/bths_pkg.sv
// shared codes and controller/datapath command and status types of the box table hit select block
// no dependencies
package bths_pkg;

	localparam logic [2:0] REQ_SELECT = 3'd0;
	localparam logic [2:0] REQ_CREATE = 3'd1;
	localparam logic [2:0] REQ_PASTE  = 3'd2;
	localparam logic [2:0] REQ_DELETE = 3'd3;
	localparam logic [2:0] REQ_CLEAR  = 3'd4;
	localparam logic [2:0] REQ_COPY   = 3'd5;

	typedef enum logic [3:0] {
		DP_IDLE,
		DP_SEL_START,
		DP_SEL_STEP,
		DP_SEL_FIN,
		DP_CREATE,
		DP_PASTE_RD,
		DP_PASTE_WR,
		DP_DEL_START,
		DP_DEL_STEP,
		DP_DEL_FIN,
		DP_CLEAR,
		DP_COPY,
		DP_NOP
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   latch;
		logic   load_rsp;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic del_ok;
		logic paste_ok;
	} dp_sts_t;

endpackage

### src/bths_req_if.sv
// request channel of the box table hit select block
// no dependencies
interface bths_req_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic [2:0]            req_type;
	logic [COORD_BITS-1:0] point_x;
	logic [COORD_BITS-1:0] point_y;
	logic [COORD_BITS-1:0] box_half_width;
	logic [COORD_BITS-1:0] box_half_height;

	modport source (
		output valid, req_type, point_x, point_y, box_half_width, box_half_height,
		input  ready
	);
	modport sink (
		input  valid, req_type, point_x, point_y, box_half_width, box_half_height,
		output ready
	);
endinterface

### src/bths_rsp_if.sv
// result channel of the box table hit select block
// no dependencies
interface bths_rsp_if #(
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
);
	logic             valid;
	logic             ready;
	logic             success;
	logic             selected_valid;
	logic [IDX_W-1:0] selected_index;
	logic             copied_valid;
	logic [IDX_W-1:0] copied_index;
	logic [CNT_W-1:0] entry_count;

	modport source (
		output valid, success, selected_valid, selected_index, copied_valid,
			copied_index, entry_count,
		input  ready
	);
	modport sink (
		input  valid, success, selected_valid, selected_index, copied_valid,
			copied_index, entry_count,
		output ready
	);
endinterface

### src/bths_ctrl.sv
// request sequencer of the box table hit select block
// depends on bths_pkg for request codes and datapath command types
module bths_ctrl
	import bths_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] req_type,
	output logic       in_ready,
	input  logic       out_ready,
	output logic       out_valid,
	output dp_cmd_t    cmd,
	input  dp_sts_t    sts
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEL_START,
		ST_SEL_WALK,
		ST_SEL_FIN,
		ST_CREATE,
		ST_PASTE_RD,
		ST_PASTE_WR,
		ST_DEL_START,
		ST_DEL_WALK,
		ST_DEL_FIN,
		ST_CLEAR,
		ST_COPY,
		ST_NOP,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.op       = DP_IDLE;
		cmd.latch    = in_valid && (state_q == ST_IDLE);
		cmd.load_rsp = 1'b0;
		unique case (state_q)
			ST_IDLE:      cmd.op = DP_IDLE;
			ST_SEL_START: cmd.op = DP_SEL_START;
			ST_SEL_WALK:  cmd.op = DP_SEL_STEP;
			ST_SEL_FIN:   cmd.op = DP_SEL_FIN;
			ST_CREATE:    cmd.op = DP_CREATE;
			ST_PASTE_RD:  cmd.op = DP_PASTE_RD;
			ST_PASTE_WR:  cmd.op = DP_PASTE_WR;
			ST_DEL_START: cmd.op = DP_DEL_START;
			ST_DEL_WALK:  cmd.op = DP_DEL_STEP;
			ST_DEL_FIN:   cmd.op = DP_DEL_FIN;
			ST_CLEAR:     cmd.op = DP_CLEAR;
			ST_COPY:      cmd.op = DP_COPY;
			ST_NOP:       cmd.op = DP_NOP;
			ST_RESP:      cmd.load_rsp = !out_valid_q || out_ready;
			default:      cmd.op = DP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_rsp) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (req_type)
							REQ_SELECT: state_q <= ST_SEL_START;
							REQ_CREATE: state_q <= ST_CREATE;
							REQ_PASTE:  state_q <= ST_PASTE_RD;
							REQ_DELETE: state_q <= ST_DEL_START;
							REQ_CLEAR:  state_q <= ST_CLEAR;
							REQ_COPY:   state_q <= ST_COPY;
							default:    state_q <= ST_NOP;
						endcase
					end
				end
				ST_SEL_START: state_q <= ST_SEL_WALK;
				ST_SEL_WALK:  if (sts.walk_done) state_q <= ST_SEL_FIN;
				ST_SEL_FIN:   state_q <= ST_RESP;
				ST_PASTE_RD:  state_q <= sts.paste_ok ? ST_PASTE_WR : ST_RESP;
				ST_DEL_START: state_q <= sts.del_ok ? ST_DEL_WALK : ST_RESP;
				ST_DEL_WALK:  if (sts.walk_done) state_q <= ST_DEL_FIN;
				ST_CREATE, ST_PASTE_WR, ST_DEL_FIN, ST_CLEAR, ST_COPY, ST_NOP: begin
					state_q <= ST_RESP;
				end
				ST_RESP:      if (cmd.load_rsp) state_q <= ST_IDLE;
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### src/bths_dp.sv
// box table memory, selection and copy registers, walk pointer and result register
// depends on bths_pkg for the command and status types
module bths_dp
	import bths_pkg::*;
#(
	parameter int MAX_ENTRIES = 64,
	parameter int COORD_BITS  = 12,
	localparam int IDX_W      = $clog2(MAX_ENTRIES),
	localparam int CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	input  logic [COORD_BITS-1:0] box_half_width,
	input  logic [COORD_BITS-1:0] box_half_height,
	output logic                  success,
	output logic                  selected_valid,
	output logic [IDX_W-1:0]      selected_index,
	output logic                  copied_valid,
	output logic [IDX_W-1:0]      copied_index,
	output logic [CNT_W-1:0]      entry_count
);

	typedef struct packed {
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
		logic [COORD_BITS-1:0] hw;
		logic [COORD_BITS-1:0] hh;
		logic                  mark;
	} box_t;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

	box_t box_mem_q [MAX_ENTRIES];

	logic [CNT_W-1:0]      cnt_q;
	logic                  sel_v_q;
	logic [IDX_W-1:0]      sel_idx_q;
	logic                  cp_v_q;
	logic [IDX_W-1:0]      cp_idx_q;
	logic                  ok_q;
	logic [CNT_W-1:0]      ptr_q;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	box_t                  rd_data_s1;
	box_t                  win_q;
	logic [COORD_BITS-1:0] px_q;
	logic [COORD_BITS-1:0] py_q;
	logic [COORD_BITS-1:0] hw_q;
	logic [COORD_BITS-1:0] hh_q;

	logic                  rsp_success_q;
	logic                  rsp_sel_v_q;
	logic [IDX_W-1:0]      rsp_sel_idx_q;
	logic                  rsp_cp_v_q;
	logic [IDX_W-1:0]      rsp_cp_idx_q;
	logic [CNT_W-1:0]      rsp_cnt_q;

	logic                  walking;
	logic                  walk_re;
	logic                  re;
	logic [IDX_W-1:0]      raddr;
	logic                  we;
	logic [IDX_W-1:0]      waddr;
	box_t                  wdata;
	box_t                  rd_clr;
	logic                  hit;
	logic                  not_full;
	logic [COORD_BITS:0]   ext_px;
	logic [COORD_BITS:0]   ext_py;
	logic [COORD_BITS:0]   ext_cx;
	logic [COORD_BITS:0]   ext_cy;
	logic [COORD_BITS:0]   ext_hw;
	logic [COORD_BITS:0]   ext_hh;

	assign not_full = (cnt_q < CNT_MAX);
	assign walking  = (cmd.op == DP_SEL_STEP) || (cmd.op == DP_DEL_STEP);
	assign walk_re  = walking && (ptr_q < cnt_q);

	assign sts.walk_done = !(ptr_q < cnt_q) && !rd_vld_s1;
	assign sts.del_ok    = sel_v_q && (CNT_W'(sel_idx_q) < cnt_q);
	assign sts.paste_ok  = cp_v_q && (CNT_W'(cp_idx_q) < cnt_q) && not_full;

	// hit test without wrap: x + hw >= cx and x <= cx + hw, same for y
	assign ext_px = {1'b0, px_q};
	assign ext_py = {1'b0, py_q};
	assign ext_cx = {1'b0, rd_data_s1.cx};
	assign ext_cy = {1'b0, rd_data_s1.cy};
	assign ext_hw = {1'b0, rd_data_s1.hw};
	assign ext_hh = {1'b0, rd_data_s1.hh};
	assign hit = (ext_px + ext_hw >= ext_cx) && (ext_px <= ext_cx + ext_hw)
		&& (ext_py + ext_hh >= ext_cy) && (ext_py <= ext_cy + ext_hh);

	always_comb begin
		rd_clr      = rd_data_s1;
		rd_clr.mark = 1'b0;
	end

	always_comb begin
		re    = 1'b0;
		raddr = ptr_q[IDX_W-1:0];
		we    = 1'b0;
		waddr = cnt_q[IDX_W-1:0];
		wdata = rd_clr;
		unique case (cmd.op)
			DP_SEL_STEP: begin
				re    = walk_re;
				we    = rd_vld_s1 && !hit;
				waddr = rd_idx_s1;
			end
			DP_SEL_FIN: begin
				we         = sel_v_q;
				waddr      = sel_idx_q;
				wdata      = win_q;
				wdata.mark = 1'b1;
			end
			DP_DEL_STEP: begin
				// shift down by one to close the gap, mark moves along
				re    = walk_re;
				we    = rd_vld_s1;
				waddr = rd_idx_s1 - IDX_W'(1);
				wdata = rd_data_s1;
			end
			DP_CREATE: begin
				we    = not_full;
				wdata = '{cx: px_q, cy: py_q, hw: hw_q, hh: hh_q, mark: 1'b0};
			end
			DP_PASTE_RD: begin
				re    = 1'b1;
				raddr = cp_idx_q;
			end
			DP_PASTE_WR: we = 1'b1;
			default: begin
				re = 1'b0;
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			box_mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_data_s1 <= box_mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			px_q <= point_x;
			py_q <= point_y;
			hw_q <= box_half_width;
			hh_q <= box_half_height;
		end
		rd_idx_s1 <= ptr_q[IDX_W-1:0];
		if (cmd.op == DP_SEL_STEP && rd_vld_s1 && hit && (rd_data_s1.mark || !sel_v_q)) begin
			win_q <= rd_data_s1;
		end
		if (cmd.load_rsp) begin
			rsp_success_q <= ok_q;
			rsp_sel_v_q   <= sel_v_q;
			rsp_sel_idx_q <= sel_idx_q;
			rsp_cp_v_q    <= cp_v_q;
			rsp_cp_idx_q  <= cp_idx_q;
			rsp_cnt_q     <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			sel_v_q   <= 1'b0;
			sel_idx_q <= '0;
			cp_v_q    <= 1'b0;
			cp_idx_q  <= '0;
			ok_q      <= 1'b0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= walk_re;
			if (walk_re) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			unique case (cmd.op)
				DP_SEL_START: begin
					sel_v_q   <= 1'b0;
					sel_idx_q <= '0;
					ok_q      <= 1'b0;
					ptr_q     <= '0;
				end
				DP_SEL_STEP: begin
					// a marked hit overrides, otherwise the first hit holds
					if (rd_vld_s1 && hit && (rd_data_s1.mark || !sel_v_q)) begin
						sel_v_q   <= 1'b1;
						sel_idx_q <= rd_idx_s1;
					end
				end
				DP_SEL_FIN:  ok_q <= sel_v_q;
				DP_CREATE: begin
					ok_q <= not_full;
					if (not_full) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				DP_PASTE_RD: ok_q <= 1'b0;
				DP_PASTE_WR: begin
					ok_q  <= 1'b1;
					cnt_q <= cnt_q + CNT_W'(1);
				end
				DP_DEL_START: begin
					ok_q  <= 1'b0;
					ptr_q <= CNT_W'(sel_idx_q) + CNT_W'(1);
				end
				DP_DEL_FIN: begin
					cnt_q     <= cnt_q - CNT_W'(1);
					sel_v_q   <= 1'b0;
					sel_idx_q <= '0;
					if (cp_v_q && (cp_idx_q == sel_idx_q)) begin
						cp_v_q   <= 1'b0;
						cp_idx_q <= '0;
						ok_q     <= 1'b1;
					end else begin
						ok_q <= 1'b0;
					end
				end
				DP_CLEAR: begin
					cnt_q     <= '0;
					sel_v_q   <= 1'b0;
					sel_idx_q <= '0;
					cp_v_q    <= 1'b0;
					cp_idx_q  <= '0;
					ok_q      <= 1'b0;
				end
				DP_COPY: begin
					cp_v_q   <= sel_v_q;
					cp_idx_q <= sel_v_q ? sel_idx_q : '0;
					ok_q     <= sel_v_q;
				end
				DP_NOP:      ok_q <= 1'b0;
				default:     ok_q <= ok_q;
			endcase
		end
	end

	assign success        = rsp_success_q;
	assign selected_valid = rsp_sel_v_q;
	assign selected_index = rsp_sel_idx_q;
	assign copied_valid   = rsp_cp_v_q;
	assign copied_index   = rsp_cp_idx_q;
	assign entry_count    = rsp_cnt_q;

endmodule

### src/box_table_hit_select.sv
// One result beat per request beat, in order. A select walks the table one entry per cycle
// through the box memory, one read and one write a cycle, over the N boxes in use; a delete
// shifts the entries above the removed one down, one per cycle; a paste that stores reads the
// copied box and then writes it at the end of the table. The walk over the memory sets how
// long a select or delete takes; a result beat that waits to be taken holds the block in its
// result state once the next request is done. One request is in work at a time; the result
// register lets a new request in while the previous result beat waits to be taken.
// No clearing pass after reset.
//
// top level of the box table hit select block
// depends on bths_pkg, bths_req_if, bths_rsp_if, bths_ctrl and bths_dp
module box_table_hit_select
	import bths_pkg::*;
#(
	parameter int MAX_ENTRIES = 64,
	parameter int COORD_BITS  = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	bths_req_if.sink   req,
	bths_rsp_if.source rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	bths_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.req_type  (req.req_type),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd),
		.sts       (sts)
	);

	bths_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.COORD_BITS  (COORD_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.point_x         (req.point_x),
		.point_y         (req.point_y),
		.box_half_width  (req.box_half_width),
		.box_half_height (req.box_half_height),
		.success         (rsp.success),
		.selected_valid  (rsp.selected_valid),
		.selected_index  (rsp.selected_index),
		.copied_valid    (rsp.copied_valid),
		.copied_index    (rsp.copied_index),
		.entry_count     (rsp.entry_count)
	);

endmodule

### src/box_table_hit_select_chk.sv
// port-level checker of the box table hit select block, bound to the top level
// depends on box_table_hit_select_assert.svh
`include "box_table_hit_select_assert.svh"

module box_table_hit_select_chk #(
	parameter int MAX_ENTRIES = 64,
	localparam int IDX_W      = $clog2(MAX_ENTRIES),
	localparam int CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             success,
	input logic             selected_valid,
	input logic [IDX_W-1:0] selected_index,
	input logic             copied_valid,
	input logic [IDX_W-1:0] copied_index,
	input logic [CNT_W-1:0] entry_count
);

	// stalled result beat holds
	`BTHS_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable(success) && $stable(selected_valid) && $stable(selected_index) && $stable(copied_valid) && $stable(copied_index) && $stable(entry_count), "result beat changed while stalled")

	// one request in work at a time
	`BTHS_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "request taken while another is in work")

	`BTHS_ASSERT_NOW(a_sel_in_table, out_valid && selected_valid, CNT_W'(selected_index) < entry_count, "selected box outside the table")

	`BTHS_ASSERT_NOW(a_copy_idx_zero, out_valid && !copied_valid, copied_index == '0, "copy index not zero without a copy mark")

	`BTHS_ASSERT_NOW(a_count_max, out_valid, entry_count <= CNT_W'(MAX_ENTRIES), "entry count above table size")

endmodule

bind box_table_hit_select box_table_hit_select_chk #(
	.MAX_ENTRIES (MAX_ENTRIES)
) u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (req.valid),
	.in_ready       (req.ready),
	.out_valid      (rsp.valid),
	.out_ready      (rsp.ready),
	.success        (rsp.success),
	.selected_valid (rsp.selected_valid),
	.selected_index (rsp.selected_index),
	.copied_valid   (rsp.copied_valid),
	.copied_index   (rsp.copied_index),
	.entry_count    (rsp.entry_count)
);

### tb/tb_top.sv
// self-checking testbench for the box table hit select block
// depends on bths_pkg, bths_req_if, bths_rsp_if and box_table_hit_select
`timescale 1ns / 1ps

module tb_top;
	import bths_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int COORD_MAX   = 4095;
	localparam int RANDOM_REQS = 1450;
	localparam int DRAIN_WAIT  = 100;

	// request codes the block leaves unused
	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [11:0] x;
		logic [11:0] y;
		logic [11:0] hw;
		logic [11:0] hh;
	} req_item_t;

	typedef struct packed {
		logic       success;
		logic       sel_v;
		logic [5:0] sel_i;
		logic       cp_v;
		logic [5:0] cp_i;
		logic [6:0] count;
	} status_t;

	logic clk;
	logic arst_n;

	bths_req_if #(.COORD_BITS(12)) req_ch ();
	bths_rsp_if #(.IDX_W(6), .CNT_W(7)) rsp_ch ();

	box_table_hit_select #(
		.MAX_ENTRIES(TABLE_DEPTH),
		.COORD_BITS (12)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// shadow of the box table
	logic [11:0] box_cx [TABLE_DEPTH];
	logic [11:0] box_cy [TABLE_DEPTH];
	logic [11:0] box_hw [TABLE_DEPTH];
	logic [11:0] box_hh [TABLE_DEPTH];
	bit          box_mark [TABLE_DEPTH];
	int          box_cnt;
	bit          sel_v;
	int          sel_i;
	bit          cp_v;
	int          cp_i;

	req_item_t req_q[$];
	status_t   status_due[$];
	req_item_t cur;
	int        gap;
	int        stall;
	int        taken;
	int        checked;
	int        miss_cnt;

	always #6 clk = ~clk;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_CLEAR;
		req_ch.point_x = '0;
		req_ch.point_y = '0;
		req_ch.box_half_width = '0;
		req_ch.box_half_height = '0;
		rsp_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// stretches where neither side idles
	function automatic bit quiet(int n);
		return ((n / 160) % 4) == 3;
	endfunction

	function automatic bit covers(int j, int x, int y);
		int cx, cy, hw, hh;
		cx = box_cx[j];
		cy = box_cy[j];
		hw = box_hw[j];
		hh = box_hh[j];
		return x >= cx - hw && x <= cx + hw && y >= cy - hh && y <= cy + hh;
	endfunction

	function automatic bit store_box(logic [11:0] cx, logic [11:0] cy, logic [11:0] hw,
			logic [11:0] hh);
		if (box_cnt >= TABLE_DEPTH)
			return 1'b0;
		box_cx[box_cnt] = cx;
		box_cy[box_cnt] = cy;
		box_hw[box_cnt] = hw;
		box_hh[box_cnt] = hh;
		box_mark[box_cnt] = 1'b0;
		box_cnt++;
		return 1'b1;
	endfunction

	task automatic table_step(input req_item_t it);
		status_t st;
		bit ok;
		int j;
		ok = 1'b0;
		case (it.kind)
			REQ_SELECT: begin
				sel_v = 1'b0;
				sel_i = 0;
				for (j = 0; j < box_cnt; j++) begin
					if (covers(j, it.x, it.y)) begin
						// a marked box takes the selection (the last marked one wins), otherwise the first hit holds
						if (box_mark[j] || !sel_v) begin
							sel_v = 1'b1;
							sel_i = j;
						end
					end else begin
						box_mark[j] = 1'b0;
					end
				end
				if (sel_v) begin
					box_mark[sel_i] = 1'b1;
					ok = 1'b1;
				end
			end
			REQ_CREATE: ok = store_box(it.x, it.y, it.hw, it.hh);
			REQ_PASTE: begin
				if (cp_v && cp_i < box_cnt)
					ok = store_box(box_cx[cp_i], box_cy[cp_i], box_hw[cp_i], box_hh[cp_i]);
			end
			REQ_DELETE: begin
				if (sel_v && sel_i < box_cnt) begin
					for (j = sel_i; j + 1 < box_cnt; j++) begin
						box_cx[j] = box_cx[j + 1];
						box_cy[j] = box_cy[j + 1];
						box_hw[j] = box_hw[j + 1];
						box_hh[j] = box_hh[j + 1];
						box_mark[j] = box_mark[j + 1];
					end
					box_cnt--;
					// copy index is not renumbered, only dropped when its box goes
					if (cp_v && cp_i == sel_i) begin
						cp_v = 1'b0;
						cp_i = 0;
						ok = 1'b1;
					end
					sel_v = 1'b0;
					sel_i = 0;
				end
			end
			REQ_CLEAR: begin
				box_cnt = 0;
				sel_v = 1'b0;
				sel_i = 0;
				cp_v = 1'b0;
				cp_i = 0;
			end
			REQ_COPY: begin
				cp_v = sel_v;
				cp_i = sel_v ? sel_i : 0;
				ok = sel_v;
			end
			default: ;
		endcase
		st.success = ok;
		st.sel_v = sel_v;
		st.sel_i = sel_v ? sel_i[5:0] : 6'd0;
		st.cp_v = cp_v;
		st.cp_i = cp_v ? cp_i[5:0] : 6'd0;
		st.count = box_cnt[6:0];
		status_due.push_back(st);
	endtask

	// request driver
	always @(posedge clk) begin : drive
		logic nv;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			gap = 0;
			taken = 0;
			box_cnt = 0;
			sel_v = 1'b0;
			sel_i = 0;
			cp_v = 1'b0;
			cp_i = 0;
		end else begin
			nv = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				table_step(cur);
				taken++;
				nv = 1'b0;
				gap = quiet(taken) ? 0 : $urandom_range(0, 4);
			end
			if (!nv) begin
				if (gap > 0) begin
					gap--;
				end else if (req_q.size() > 0) begin
					cur = req_q.pop_front();
					nv = 1'b1;
					req_ch.req_type <= cur.kind;
					req_ch.point_x <= cur.x;
					req_ch.point_y <= cur.y;
					req_ch.box_half_width <= cur.hw;
					req_ch.box_half_height <= cur.hh;
				end
			end
			req_ch.valid <= nv;
		end
	end

	// result monitor
	always @(posedge clk) begin : watch
		status_t got, want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall = 0;
			checked = 0;
			miss_cnt = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.success = rsp_ch.success;
				got.sel_v = rsp_ch.selected_valid;
				got.sel_i = rsp_ch.selected_index;
				got.cp_v = rsp_ch.copied_valid;
				got.cp_i = rsp_ch.copied_index;
				got.count = rsp_ch.entry_count;
				if (status_due.size() == 0) begin
					miss_cnt++;
					if (miss_cnt <= 10)
						$display("result beat %0d with nothing due: ok=%b sel=%b/%0d cp=%b/%0d cnt=%0d",
							checked, got.success, got.sel_v, got.sel_i, got.cp_v, got.cp_i,
							got.count);
				end else begin
					want = status_due.pop_front();
					if (got !== want) begin
						miss_cnt++;
						if (miss_cnt <= 10)
							$display({"result beat %0d mismatch: exp ok=%b sel=%b/%0d cp=%b/%0d ",
								"cnt=%0d, got ok=%b sel=%b/%0d cp=%b/%0d cnt=%0d"}, checked,
								want.success, want.sel_v, want.sel_i, want.cp_v, want.cp_i,
								want.count, got.success, got.sel_v, got.sel_i, got.cp_v,
								got.cp_i, got.count);
					end
				end
				checked++;
				stall = quiet(checked) ? 0 : $urandom_range(0, 4);
			end
			if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic push_req(logic [2:0] kind, int x, int y, int hw, int hh);
		req_item_t it;
		while (req_q.size() >= 2)
			@(negedge clk);
		it.kind = kind;
		it.x = x[11:0];
		it.y = y[11:0];
		it.hw = hw[11:0];
		it.hh = hh[11:0];
		req_q.push_back(it);
	endtask

	function automatic int near(int c, int h);
		int v;
		v = c - h - 2 + int'($urandom_range(0, 2 * h + 4));
		if (v < 0)
			v = 0;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v;
	endfunction

	function automatic int pick_half();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return $urandom_range(0, COORD_MAX);
		return $urandom_range(0, 400);
	endfunction

	// select point, mostly aimed at a box in the table
	task automatic push_select();
		int j;
		if (box_cnt > 0 && $urandom_range(0, 9) < 8) begin
			j = $urandom_range(0, box_cnt - 1);
			push_req(REQ_SELECT, near(box_cx[j], box_hw[j]), near(box_cy[j], box_hh[j]),
				$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
		end else begin
			push_req(REQ_SELECT, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
				$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
		end
	endtask

	task automatic push_other(logic [2:0] kind);
		push_req(kind, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
			$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
	endtask

	initial begin : stimulus
		int n, r, mode;
		@(posedge arst_n);
		@(negedge clk);

		// empty table corner cases
		push_req(REQ_SELECT, 100, 100, 0, 0);
		push_req(REQ_COPY, 0, 0, 0, 0);
		push_req(REQ_PASTE, 0, 0, 0, 0);
		push_req(REQ_DELETE, 0, 0, 0, 0);
		push_req(REQ_SPARE_LO, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		push_req(REQ_SPARE_HI, 0, 0, 0, 0);
		// extreme boxes and overlapping ones
		push_req(REQ_CREATE, 0, 0, 0, 0);
		push_req(REQ_CREATE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		push_req(REQ_CREATE, 2048, 2048, 100, 50);
		push_req(REQ_CREATE, 2048, 2048, 200, 200);
		push_req(REQ_SELECT, 0, 0, 0, 0);
		push_req(REQ_SELECT, 0, 0, 0, 0);
		push_req(REQ_SELECT, 2048, 2048, 0, 0);
		push_req(REQ_SELECT, 2148, 2098, 0, 0);
		push_req(REQ_SELECT, 2149, 2048, 0, 0);
		push_req(REQ_COPY, 0, 0, 0, 0);
		push_req(REQ_PASTE, 0, 0, 0, 0);
		push_req(REQ_SELECT, COORD_MAX, COORD_MAX, 0, 0);
		push_req(REQ_DELETE, 0, 0, 0, 0);
		// box with edges past both ends of the coordinate range
		push_req(REQ_CREATE, 10, 4090, 20, 20);
		push_req(REQ_SELECT, 0, COORD_MAX, 0, 0);
		push_req(REQ_COPY, 0, 0, 0, 0);
		push_req(REQ_DELETE, 0, 0, 0, 0);
		push_req(REQ_CLEAR, 0, 0, 0, 0);
		push_req(REQ_PASTE, 0, 0, 0, 0);

		mode = 0;
		for (n = 0; n < RANDOM_REQS; n++) begin
			if (n % 120 == 0)
				mode = $urandom_range(0, 2);
			r = $urandom_range(0, 99);
			if (mode == 0) begin
				// filling up, runs into the full table
				if (r < 65)
					push_req(REQ_CREATE, $urandom_range(0, COORD_MAX),
						$urandom_range(0, COORD_MAX), pick_half(), pick_half());
				else if (r < 78)
					push_other(REQ_PASTE);
				else if (r < 94)
					push_select();
				else
					push_other(REQ_COPY);
			end else begin
				if (r < 38)
					push_select();
				else if (r < (mode == 1 ? 60 : 50))
					push_req(REQ_CREATE, $urandom_range(0, COORD_MAX),
						$urandom_range(0, COORD_MAX), pick_half(), pick_half());
				else if (r < 68)
					push_other(REQ_PASTE);
				else if (r < 82)
					push_other(REQ_DELETE);
				else if (r < 93)
					push_other(REQ_COPY);
				else if (r < 95)
					push_other(REQ_CLEAR);
				else if (r < 97)
					push_other($urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO);
				else
					push_select();
			end
		end

		while (req_q.size() != 0 || req_ch.valid || status_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (miss_cnt == 0 && status_due.size() == 0) begin
			$display("[box_table_hit_select] OK");
		end else begin
			$display("[box_table_hit_select] ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#10ms;
		$display("[box_table_hit_select] ERROR");
		$finish;
	end

endmodule

### box_table_hit_select.f
+incdir+src
src/bths_pkg.sv
src/bths_req_if.sv
src/bths_rsp_if.sv
src/bths_ctrl.sv
src/bths_dp.sv
src/box_table_hit_select.sv
src/box_table_hit_select_chk.sv
tb/tb_top.sv
